// ===== hw/rtl/cf_pkg.sv =====
package cf_pkg;

    localparam int MAX_TAPS    = 32;
    localparam int MAX_FILTERS = 16;
    localparam int MAX_WINDOWS = 4096;

    // One weight row per filter: the taps, then the bias.
    localparam int ROW_LEN   = MAX_TAPS + 1;
    localparam int BIAS_SLOT = MAX_TAPS;
    localparam int WT_DEPTH  = MAX_FILTERS * ROW_LEN;
    localparam int ADDR_W    = $clog2(WT_DEPTH);

    localparam int TAP_W  = 6;
    localparam int STR_W  = 8;
    localparam int FLT_W  = 5;
    localparam int FIDX_W = 4;
    localparam int SMP_W  = 16;
    localparam int WGT_W  = 16;
    localparam int VAL_W  = 40;
    localparam int PRD_W  = SMP_W + WGT_W;
    localparam int WIN_W  = $clog2(MAX_WINDOWS);
    localparam int SEEN_W = 13;
    localparam int CNT_W  = $clog2(MAX_TAPS + 3);

    // Sequencer step at which the last product has reached the accumulator.
    localparam int DRAIN_END = MAX_TAPS + 2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_TAPS    = 2'd0;
    localparam logic [1:0] REG_STRIDE  = 2'd1;
    localparam logic [1:0] REG_FILTERS = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } t_state;

    // Kind of operand pair that enters the multiply stage.
    typedef struct packed {
        logic bias;
        logic tap;
    } t_mac_ctl;

endpackage

// ===== hw/rtl/cf_ram.sv =====
module cf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 528
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/cf_cell.sv =====
module cf_cell import cf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [SMP_W-1:0] i_data,
    output logic [SMP_W-1:0] o_data
);

    logic [SMP_W-1:0] r_data;

    // The cell takes its neighbor's sample on a shift or a rotation step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_en) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

// ===== hw/rtl/cf_mac.sv =====
module cf_mac import cf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  t_mac_ctl         i_ctl,
    input  logic [WGT_W-1:0] i_weight,
    input  logic [SMP_W-1:0] i_sample,
    output logic [VAL_W-1:0] o_acc
);

    logic [PRD_W-1:0] r_prod;
    logic             r_prod_v;
    logic [VAL_W-1:0] r_acc;
    logic [PRD_W-1:0] n_prod;

    // A tap multiplies with its sample; the bias moves up to the product scale.
    always_comb begin
        n_prod = '0;
        if (i_ctl.tap) begin
            n_prod = PRD_W'($signed(i_weight) * $signed(i_sample));
        end else if (i_ctl.bias) begin
            n_prod = {{(PRD_W - WGT_W - 8){i_weight[WGT_W-1]}}, i_weight, 8'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
        end else begin
            r_prod_v <= i_ctl.tap | i_ctl.bias;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    // Full-width accumulation of the registered products.
    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + {{(VAL_W - PRD_W){r_prod[PRD_W-1]}}, r_prod};
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== hw/rtl/conv1d_filter_bank.sv =====
// A sample that closes a window starts one pass per filter in use. Each pass makes one
// weight-memory read a cycle while the sample ring rotates past the multiply stage, then
// drains the multiply stage and loads the output register. The input stalls until the
// last pass is done; samples that close no window and weight writes do not stall it.
// Reset (synchronous, active low) clears the delay line, counters and sequencer and sets the
// configuration registers to one; the weight memory holds nothing defined until written.
module conv1d_filter_bank import cf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_action,
    input  logic [SMP_W-1:0]  i_sample,
    input  logic              i_first,
    input  logic [FIDX_W-1:0] i_filter_index,
    input  logic [TAP_W-1:0]  i_tap_index,
    input  logic [WGT_W-1:0]  i_weight,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [VAL_W-1:0]  o_value,
    output logic [3:0]        o_filter_number,
    output logic [11:0]       o_window_number,
    output logic              o_last
);

    logic [TAP_W-1:0]  r_taps;
    logic [STR_W-1:0]  r_stride;
    logic [FLT_W-1:0]  r_filters;
    logic [TAP_W-1:0]  eff_taps;
    logic [STR_W-1:0]  eff_stride;
    logic [FLT_W-1:0]  eff_filters;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_step, n_step;
    logic [FIDX_W-1:0] r_flt, n_flt;

    logic [SEEN_W-1:0] r_seen;
    logic [STR_W-1:0]  r_cd;
    logic [WIN_W-1:0]  r_wc;
    logic [WIN_W-1:0]  r_win;

    logic              accept;
    logic              push;
    logic              wr_item;
    logic [SEEN_W-1:0] seen0, n_seen;
    logic [STR_W-1:0]  cd0, n_cd;
    logic [WIN_W-1:0]  wc0;
    logic              emit;

    logic [TAP_W-1:0]  base;
    logic [CNT_W-1:0]  step_m1;
    logic              tap_ok;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    logic [TAP_W-1:0]  wslot;
    logic              we;
    logic [WGT_W-1:0]  rdata;

    logic              run;
    logic              rotate;
    logic              acc_clear;
    logic              out_load;
    logic              out_free;
    logic              last_flt;

    logic [SMP_W-1:0]  ring [MAX_TAPS];
    logic [SMP_W-1:0]  ring_in [MAX_TAPS];
    logic              ring_en;
    logic [SMP_W-1:0]  r_samp;
    t_mac_ctl          r_ctl;
    logic [VAL_W-1:0]  acc;

    // Configuration port: writes land in the setup/access pair, reads are direct.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps    <= TAP_W'(1);
            r_stride  <= STR_W'(1);
            r_filters <= FLT_W'(1);
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_TAPS:    r_taps    <= pwdata[TAP_W-1:0];
                REG_STRIDE:  r_stride  <= pwdata[STR_W-1:0];
                REG_FILTERS: r_filters <= pwdata[FLT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_TAPS:    prdata = 32'(r_taps);
            REG_STRIDE:  prdata = 32'(r_stride);
            REG_FILTERS: prdata = 32'(r_filters);
            default:     prdata = '0;
        endcase
    end

    // Out-of-range register values are clamped to the nearest legal one.
    always_comb begin
        if (r_taps == '0) begin
            eff_taps = TAP_W'(1);
        end else if (r_taps > TAP_W'(MAX_TAPS)) begin
            eff_taps = TAP_W'(MAX_TAPS);
        end else begin
            eff_taps = r_taps;
        end
        eff_stride = (r_stride == '0) ? STR_W'(1) : r_stride;
        if (r_filters == '0) begin
            eff_filters = FLT_W'(1);
        end else if (r_filters > FLT_W'(MAX_FILTERS)) begin
            eff_filters = FLT_W'(MAX_FILTERS);
        end else begin
            eff_filters = r_filters;
        end
    end

    // Input transfers are taken only while the sequencer is idle.
    assign o_stall = (r_state != ST_IDLE);
    assign accept  = i_valid && !o_stall;
    assign push    = accept && i_action;
    assign wr_item = accept && !i_action;

    // Window bookkeeping for a sample push.
    always_comb begin
        seen0  = i_first ? '0 : r_seen;
        cd0    = i_first ? '0 : r_cd;
        wc0    = i_first ? '0 : r_wc;
        emit   = 1'b0;
        n_cd   = cd0;
        if (seen0 < SEEN_W'(eff_taps)) begin
            n_seen = seen0 + SEEN_W'(1);
            if (n_seen == SEEN_W'(eff_taps)) begin
                n_cd = eff_stride - STR_W'(1);
                emit = 1'b1;
            end
        end else begin
            n_seen = (seen0 != '1) ? seen0 + SEEN_W'(1) : seen0;
            if (cd0 == '0) begin
                n_cd = eff_stride - STR_W'(1);
                emit = 1'b1;
            end else begin
                n_cd = cd0 - STR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_cd   <= '0;
            r_wc   <= '0;
        end else if (push) begin
            r_seen <= n_seen;
            r_cd   <= n_cd;
            r_wc   <= emit ? wc0 + WIN_W'(1) : wc0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_win <= wc0;
        end
    end

    // Sequencer next state.
    assign last_flt = ({1'b0, r_flt} + FLT_W'(1)) == eff_filters;
    assign out_free = !o_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_flt   = r_flt;
        unique case (r_state)
            ST_IDLE: begin
                n_step = '0;
                n_flt  = '0;
                if (push && emit) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_step = r_step + CNT_W'(1);
                if (r_step == CNT_W'(MAX_TAPS)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_step = r_step + CNT_W'(1);
                if (r_step == CNT_W'(DRAIN_END)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_step = '0;
                    if (last_flt) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_flt   = r_flt + FIDX_W'(1);
                        n_state = ST_RUN;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_flt   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_flt   <= n_flt;
        end
    end

    // Sequencer outputs: weight address, ring rotation, accumulator control and output load.
    assign base    = TAP_W'(MAX_TAPS) - eff_taps;
    assign step_m1 = r_step - CNT_W'(1);

    always_comb begin
        run       = (r_state == ST_RUN);
        tap_ok    = run && (r_step != '0) && (step_m1 >= CNT_W'(base));
        rotate    = run && (r_step != '0);
        acc_clear = run && (r_step == '0);
        out_load  = (r_state == ST_OUT) && out_free;
        if (tap_ok) begin
            raddr = ADDR_W'(r_flt) * ADDR_W'(ROW_LEN) + ADDR_W'(step_m1 - CNT_W'(base));
        end else begin
            raddr = ADDR_W'(r_flt) * ADDR_W'(ROW_LEN) + ADDR_W'(BIAS_SLOT);
        end
    end

    // Weight writes: the slot equal to the window length holds the bias.
    assign wslot = (i_tap_index == eff_taps) ? TAP_W'(BIAS_SLOT) : i_tap_index;
    assign waddr = ADDR_W'(i_filter_index) * ADDR_W'(ROW_LEN) + ADDR_W'(wslot);
    assign we    = wr_item && (i_tap_index <= eff_taps)
                   && ({1'b0, i_filter_index} < FLT_W'(MAX_FILTERS));

    cf_ram #(
        .WIDTH (WGT_W),
        .DEPTH (WT_DEPTH)
    ) u_wt_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_weight),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Sample ring: shifts in a new sample on a push, rotates during a filter pass.
    assign ring_en = push || rotate;

    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
        if (k == MAX_TAPS - 1) begin : g_tail
            assign ring_in[k] = push ? i_sample : ring[0];
        end else begin : g_body
            assign ring_in[k] = ring[k+1];
        end
        cf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (ring_en),
            .i_data  (ring_in[k]),
            .o_data  (ring[k])
        );
    end

    // The head sample lines up with the weight read issued in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl.bias <= acc_clear;
            r_ctl.tap  <= tap_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_samp <= ring[0];
    end

    cf_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (acc_clear),
        .i_ctl    (r_ctl),
        .i_weight (rdata),
        .i_sample (r_samp),
        .o_acc    (acc)
    );

    // Output register, loaded once per filter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (out_load) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_value         <= acc;
            o_filter_number <= r_flt;
            o_window_number <= r_win;
            o_last          <= last_flt;
        end
    end

endmodule

// ===== bench/tb_conv1d_filter_bank.sv =====
`timescale 1ns / 1ps

module tb_conv1d_filter_bank;
    import cf_pkg::*;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic [3:0]       filter_number;
        logic [11:0]      window_number;
        logic             last;
    } t_response;

    // Scoreboard: a private copy of the filter bank that predicts every response.
    class filter_bank_scoreboard;
        logic [SMP_W-1:0] delay_line [MAX_TAPS];
        logic [WGT_W-1:0] weights [MAX_FILTERS][ROW_LEN];
        int unsigned seen, countdown, win_count;
        int unsigned taps_reg, stride_reg, filters_reg;
        t_response   pending_q[$];
        int          errors;
        int          delivered;

        function new();
            foreach (delay_line[i]) delay_line[i] = '0;
            foreach (weights[f, k]) weights[f][k] = '0;
            seen = 0; countdown = 0; win_count = 0;
            taps_reg = 1; stride_reg = 1; filters_reg = 1;
            errors = 0; delivered = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_TAPS:    taps_reg    = val[5:0];
                REG_STRIDE:  stride_reg  = val[7:0];
                REG_FILTERS: filters_reg = val[4:0];
                default: ;
            endcase
        endfunction

        function int unsigned taps_eff();
            if (taps_reg == 0) return 1;
            if (taps_reg > MAX_TAPS) return MAX_TAPS;
            return taps_reg;
        endfunction

        function int unsigned stride_eff();
            return (stride_reg == 0) ? 1 : stride_reg;
        endfunction

        // Queue one response per filter in use for the current window.
        function void predict_window();
            int unsigned t, nf, base;
            longint acc;
            t_response r;
            t = taps_eff();
            nf = (filters_reg == 0) ? 1 : (filters_reg > MAX_FILTERS ? MAX_FILTERS : filters_reg);
            base = MAX_TAPS - t;
            for (int f = 0; f < nf; f++) begin
                acc = longint'($signed(weights[f][BIAS_SLOT])) * 256;
                for (int i = 0; i < t; i++)
                    acc += longint'($signed(weights[f][i])) *
                           longint'($signed(delay_line[base + i]));
                r.value = acc[VAL_W-1:0];
                r.filter_number = f[3:0];
                r.window_number = win_count[11:0];
                r.last = (f + 1 == nf);
                pending_q.push_back(r);
            end
            win_count = (win_count + 1) % MAX_WINDOWS;
        endfunction

        function void note_input(logic act, logic [SMP_W-1:0] smp, logic fst,
                                 logic [FIDX_W-1:0] fidx, logic [TAP_W-1:0] tidx,
                                 logic [WGT_W-1:0] wgt);
            int unsigned t;
            t = taps_eff();
            if (!act) begin
                if (tidx == t) weights[fidx][BIAS_SLOT] = wgt;
                else if (tidx < t) weights[fidx][tidx] = wgt;
                return;
            end
            if (fst) begin
                seen = 0; countdown = 0; win_count = 0;
            end
            for (int i = 0; i < MAX_TAPS - 1; i++) delay_line[i] = delay_line[i + 1];
            delay_line[MAX_TAPS - 1] = smp;
            if (seen < t) begin
                seen++;
                if (seen == t) begin
                    countdown = (stride_eff() - 1) & 8'hFF;
                    predict_window();
                end
                return;
            end
            if (seen < 8191) seen++;
            if (countdown == 0) begin
                countdown = (stride_eff() - 1) & 8'hFF;
                predict_window();
            end else begin
                countdown--;
            end
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic [VAL_W-1:0] val, logic [3:0] fn, logic [11:0] wn,
                          logic lst);
            t_response r;
            delivered++;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected response value %h filter %0d", val, fn));
                return;
            end
            r = pending_q.pop_front();
            if (val !== r.value)
                report($sformatf("value %h, want %h", val, r.value));
            if (fn !== r.filter_number)
                report($sformatf("filter_number %0d, want %0d", fn, r.filter_number));
            if (wn !== r.window_number)
                report($sformatf("window_number %0d, want %0d", wn, r.window_number));
            if (lst !== r.last)
                report($sformatf("last %0b, want %0b", lst, r.last));
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_action = 1'b0;
    logic [SMP_W-1:0]  i_sample = '0;
    logic              i_first = 1'b0;
    logic [FIDX_W-1:0] i_filter_index = '0;
    logic [TAP_W-1:0]  i_tap_index = '0;
    logic [WGT_W-1:0]  i_weight = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [VAL_W-1:0]  o_value;
    logic [3:0]        o_filter_number;
    logic [11:0]       o_window_number;
    logic              o_last;

    filter_bank_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request = 0;

    conv1d_filter_bank dut (.*);

    always #5 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("tb_conv1d_filter_bank NOT OK");
        $finish;
    end

    // Receiver side: random stalls, plus one long hold-off counted here.
    always @(negedge i_clk) begin
        int hold_left;
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Every response transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_value, o_filter_number, o_window_number, o_last);
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // One input transfer, with a random gap in front of it.
    task automatic send_item(logic act, logic [SMP_W-1:0] smp, logic fst,
                             logic [FIDX_W-1:0] fidx, logic [TAP_W-1:0] tidx,
                             logic [WGT_W-1:0] wgt);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1; i_action <= act; i_sample <= smp; i_first <= fst;
        i_filter_index <= fidx; i_tap_index <= tidx; i_weight <= wgt;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        sb.note_input(act, smp, fst, fidx, tidx, wgt);
    endtask

    task automatic send_random_item(int weight_pct, int first_pct);
        logic [15:0]      v;
        logic [TAP_W-1:0] tidx;
        v = 16'($urandom());
        case ($urandom_range(7))
            0: v = 16'h7FFF;
            1: v = 16'h8000;
            default: ;
        endcase
        tidx = ($urandom_range(3) == 0) ? TAP_W'($urandom_range(63))
                                        : TAP_W'($urandom_range(sb.taps_eff()));
        if ($urandom_range(99) < weight_pct)
            send_item(1'b0, SMP_W'($urandom()), 1'($urandom()), FIDX_W'($urandom()),
                      tidx, v);
        else
            send_item(1'b1, v, ($urandom_range(99) < first_pct), '0, '0, '0);
    endtask

    // Quiet the sender and let the block finish any window still in flight.
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending_q.size() > 0) @(posedge i_clk);
        repeat ((MAX_TAPS + 4) * MAX_FILTERS + 24) @(posedge i_clk);
    endtask

    initial begin
        int taps_set [3] = '{0, 5, 63};
        int stride_set [3] = '{0, 3, 1};
        int filt_set [3] = '{0, 1, 1};
        int count_set [3] = '{6, 8, 33};
        int wpct_set [3] = '{15, 15, 0};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill every weight slot that a later window reads: the whole row of
        // filter 0, and tap 0 plus the bias of every other filter.
        write_reg(REG_TAPS, 32);
        write_reg(REG_STRIDE, 1);
        write_reg(REG_FILTERS, 16);
        for (int k = 0; k <= MAX_TAPS; k++)
            send_item(1'b0, SMP_W'($urandom()), 1'($urandom()), '0, TAP_W'(k),
                      (k % 3 == 0) ? 16'h8000 : (k % 3 == 1) ? 16'h7FFF
                                                             : WGT_W'($urandom()));
        for (int f = 1; f < MAX_FILTERS; f++) begin
            send_item(1'b0, SMP_W'($urandom()), 1'($urandom()), FIDX_W'(f), '0,
                      WGT_W'($urandom()));
            send_item(1'b0, SMP_W'($urandom()), 1'($urandom()), FIDX_W'(f),
                      TAP_W'(BIAS_SLOT), (f % 2) ? 16'h8000 : 16'h7FFF);
        end

        // Directed: ignored writes beyond the window length.
        send_item(1'b0, 16'hFFFF, 1'b1, 4'd15, 6'd63, 16'h1234);
        send_item(1'b0, 16'h0000, 1'b0, 4'd0, 6'd33, 16'hFFFF);
        drain();

        // Directed: every filter in use, extreme samples, a long receiver hold.
        write_reg(REG_TAPS, 1);
        write_reg(REG_FILTERS, 31);
        hold_request = 400;
        send_item(1'b1, 16'h7FFF, 1'b1, 4'hF, 6'h3F, 16'hFFFF);
        send_item(1'b1, 16'h8000, 1'b0, '0, '0, '0);
        send_item(1'b1, 16'h7FFF, 1'b0, '0, '0, '0);
        send_item(1'b1, 16'h8000, 1'b0, '0, '0, '0);
        drain();

        // Random phases across register settings and idling patterns.
        for (int p = 0; p < 3; p++) begin
            if (p == 0) begin
                send_idle_pct = 6; recv_idle_pct = 88;
            end else if (p == 1) begin
                send_idle_pct = 88; recv_idle_pct = 6;
            end else begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            write_reg(REG_TAPS, taps_set[p]);
            write_reg(REG_STRIDE, stride_set[p]);
            write_reg(REG_FILTERS, filt_set[p]);
            send_item(1'b1, SMP_W'($urandom()), 1'b1, '0, '0, '0);
            for (int i = 1; i < count_set[p]; i++)
                send_random_item(wpct_set[p], (p == 2) ? 0 : 4);
            drain();
        end

        if (sb.errors == 0)
            $display("tb_conv1d_filter_bank OK");
        else
            $display("tb_conv1d_filter_bank NOT OK");
        $finish;
    end

endmodule
